FILE: src/lrst_pkg.sv
// ----------------------------------------------------------------------------
// lrst_pkg: shared types and constants of the longest-run segment tree
// Node record, payload structs, operation and status codes, and the leaf builder.
// ----------------------------------------------------------------------------
package lrst_pkg;

	localparam int MAX_LEN_DEF    = 1024;
	localparam int TREE_NODES_DEF = 4096;
	localparam int RUN_W = 11;
	localparam int SYM_W = 8;
	localparam int POS_W = 10;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_BUILD  = 2'd1;
	localparam logic [1:0] FUNC_UPDATE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [POS_W-1:0] position;
		logic [SYM_W-1:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [RUN_W-1:0] longest_run;
		logic [1:0]       status;
	} out_word_t;

	// Node record, 60 bits wide.
	typedef struct packed {
		logic [RUN_W-1:0] len;
		logic [RUN_W-1:0] pre;
		logic [RUN_W-1:0] suf;
		logic [RUN_W-1:0] best;
		logic [SYM_W-1:0] first;
		logic [SYM_W-1:0] last;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

	function automatic seg_t leaf(input logic [SYM_W-1:0] c);
		seg_t v;
		v.len = RUN_W'(1);
		v.pre = RUN_W'(1);
		v.suf = RUN_W'(1);
		v.best = RUN_W'(1);
		v.first = c;
		v.last = c;
		return v;
	endfunction

endpackage

FILE: src/lrst_ram.sv
// ----------------------------------------------------------------------------
// lrst_ram: generic single-port RAM
// One write or one read a cycle; the read data is registered.
// ----------------------------------------------------------------------------
module lrst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: src/lrst_join.sv
// ----------------------------------------------------------------------------
// lrst_join: merge unit of the tree
// Combines a left and a right child record into their parent record.
// ----------------------------------------------------------------------------
module lrst_join
	import lrst_pkg::*;
(
	input  seg_t a,
	input  seg_t b,
	output seg_t p
);
	logic             touch;
	logic [RUN_W-1:0] mid_run;
	logic [RUN_W-1:0] best_ab;

	always_comb begin
		touch   = (a.last == b.first);
		mid_run = a.suf + b.pre;
		best_ab = (a.best > b.best) ? a.best : b.best;
		p.len   = a.len + b.len;
		p.first = a.first;
		p.last  = b.last;
		p.pre   = (touch && a.pre == a.len) ? a.pre + b.pre : a.pre;
		p.suf   = (touch && b.suf == b.len) ? b.suf + a.suf : b.suf;
		p.best  = (touch && mid_run > best_ab) ? mid_run : best_ab;
	end
endmodule

FILE: src/longest_run_segment_tree_core.sv
// ----------------------------------------------------------------------------
// longest_run_segment_tree_core: longest repeated run over a segment tree
// Loads characters, builds the tree, and applies point updates with a path
// re-merge, reporting the longest run of one character in the whole string.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | in_valid, in_stall, in_data      | into core
//  result   | out_valid, out_stall, out_data   | out of core
//  config   | cfg_valid, cfg_ready, cfg_data   | into core
//
// A load writes its character on acceptance. Build and update walk the tree with an
// explicit stack through the single node RAM port. An internal node takes the steps
// push, revisit, left read, right read and parent write; a build leaf takes visit, character
// read and leaf write, and an update leaf is written on its visit. Both end by reading the
// root record for the result.
// Reset clears the state, the built mark and sets length to 1; the RAMs are
// not cleared. A result is held in an output register; a stalled result
// holds the core busy, so the next word is accepted once the result leaves.
// A length write offered while idle takes priority and stalls the input.
//
module longest_run_segment_tree_core
	import lrst_pkg::*;
#(
	parameter int MAX_LEN    = MAX_LEN_DEF,
	parameter int TREE_NODES = TREE_NODES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [RUN_W-1:0] cfg_data
);
	localparam int NA_W  = $clog2(TREE_NODES);
	localparam int CA_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	// A build holds each ancestor and its pending right sibling, plus the node.
	localparam int DEP   = 2 * $clog2(MAX_LEN) + 2;
	localparam int SP_W  = $clog2(DEP + 1);
	localparam int IX_W  = 18;
	localparam int NK_W  = NA_W + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_VISIT = 4'd1;
	localparam logic [3:0] S_CRD   = 4'd2;
	localparam logic [3:0] S_CWT   = 4'd3;
	localparam logic [3:0] S_RDL   = 4'd4;
	localparam logic [3:0] S_RDR   = 4'd5;
	localparam logic [3:0] S_WRP   = 4'd6;
	localparam logic [3:0] S_ROOT  = 4'd8;
	localparam logic [3:0] S_RWT   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	// One stack frame: node, range, and whether its children are done.
	typedef struct packed {
		logic [NK_W-1:0] k;
		logic [IX_W-1:0] lo;
		logic [IX_W-1:0] hi;
		logic            back;
	} frame_t;

	logic [3:0]       state_q;
	logic [RUN_W-1:0] len_q;
	logic             built_q;
	in_word_t         item_q;
	out_word_t        res_q;
	frame_t           stk_q [DEP];
	logic [SP_W-1:0]  sp_q;
	seg_t             left_q, right_q;

	frame_t           top;
	logic [IX_W-1:0]  mid;
	seg_t             joined;
	logic             pos_bad;

	logic             n_we;
	logic [NA_W-1:0]  n_addr;
	seg_t             n_wdata, n_rdata;
	logic             c_we;
	logic [CA_W-1:0]  c_addr;
	logic [SYM_W-1:0] c_wdata, c_rdata;

	lrst_ram #(.WIDTH(SEG_W), .DEPTH(TREE_NODES)) u_nodes (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
	);
	lrst_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_chars (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);
	lrst_join u_join (.a(left_q), .b(right_q), .p(joined));

	assign top       = stk_q[sp_q[SP_W-1:0] - SP_W'(1)];
	assign mid       = IX_W'((top.lo + top.hi) >> 1);
	assign pos_bad   = (RUN_W'(in_data.position) >= len_q);
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	// RAM port control, driven from the sequencer state.
	always_comb begin
		n_we    = 1'b0;
		n_addr  = NA_W'(top.k);
		n_wdata = joined;
		c_we    = 1'b0;
		c_addr  = CA_W'(top.lo);
		c_wdata = item_q.symbol;
		unique case (state_q)
			S_IDLE: begin
				c_we   = in_valid && !cfg_valid && in_data.func == FUNC_LOAD && !pos_bad;
				c_addr = CA_W'(in_data.position);
				c_wdata = in_data.symbol;
			end
			S_VISIT: begin
				if (top.lo >= top.hi && item_q.func == FUNC_UPDATE) begin
					n_we    = 1'b1;
					n_wdata = leaf(item_q.symbol);
					c_we    = 1'b1;
				end else if (top.back) begin
					n_addr = NA_W'({top.k, 1'b0});
				end
			end
			S_CWT: begin
				n_we    = 1'b1;
				n_wdata = leaf(c_rdata);
			end
			S_RDL:  n_addr = NA_W'({top.k, 1'b1});
			S_WRP: begin
				n_we = 1'b1;
			end
			S_ROOT, S_RWT: n_addr = NA_W'(1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= RUN_W'(1);
			built_q <= 1'b0;
			sp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_data == '0) len_q <= RUN_W'(1);
						else if (cfg_data > RUN_W'(MAX_LEN)) len_q <= RUN_W'(MAX_LEN);
						else len_q <= cfg_data;
						built_q <= 1'b0;
					end else if (in_valid) begin
						item_q <= in_data;
						res_q.longest_run <= '0;
						if (in_data.func == FUNC_LOAD && pos_bad) begin
							res_q.status <= ST_RANGE;
							state_q <= S_OUT;
						end else if (in_data.func == FUNC_LOAD) begin
							res_q.status <= ST_OK;
							built_q <= 1'b0;
							state_q <= S_OUT;
						end else if (in_data.func == FUNC_UPDATE && pos_bad) begin
							res_q.status <= ST_RANGE;
							state_q <= S_OUT;
						end else if (in_data.func == FUNC_UPDATE && !built_q) begin
							res_q.status <= ST_NOT_BUILT;
							state_q <= S_OUT;
						end else if (in_data.func == FUNC_BUILD ||
							in_data.func == FUNC_UPDATE) begin
							res_q.status <= ST_OK;
							stk_q[0] <= '{k: NK_W'(1), lo: '0,
								hi: IX_W'(len_q - RUN_W'(1)), back: 1'b0};
							sp_q    <= SP_W'(1);
							state_q <= S_VISIT;
						end else begin
							res_q.status <= ST_OK;
							state_q <= S_OUT;
						end
					end
				end
				S_VISIT: begin
					if (top.lo >= top.hi) begin
						if (item_q.func == FUNC_UPDATE) begin
							sp_q    <= sp_q - SP_W'(1);
							state_q <= (sp_q == SP_W'(1)) ? S_ROOT : S_VISIT;
						end else begin
							state_q <= S_CRD;
						end
					end else if (top.back) begin
						state_q <= S_RDL;
					end else begin
						stk_q[sp_q - SP_W'(1)].back <= 1'b1;
						if (item_q.func == FUNC_BUILD) begin
							// Right child lies below the left one, so left runs first.
							stk_q[sp_q] <= '{k: NK_W'({top.k, 1'b1}), lo: IX_W'(mid + 1'b1),
								hi: top.hi, back: 1'b0};
							stk_q[sp_q + SP_W'(1)] <= '{k: NK_W'({top.k, 1'b0}),
								lo: top.lo, hi: mid, back: 1'b0};
							sp_q <= sp_q + SP_W'(2);
						end else begin
							if (IX_W'(item_q.position) <= mid)
								stk_q[sp_q] <= '{k: NK_W'({top.k, 1'b0}), lo: top.lo,
									hi: mid, back: 1'b0};
							else
								stk_q[sp_q] <= '{k: NK_W'({top.k, 1'b1}),
									lo: IX_W'(mid + 1'b1), hi: top.hi, back: 1'b0};
							sp_q <= sp_q + SP_W'(1);
						end
					end
				end
				S_CRD: state_q <= S_CWT;
				S_CWT: begin
					sp_q    <= sp_q - SP_W'(1);
					state_q <= (sp_q == SP_W'(1)) ? S_ROOT : S_VISIT;
				end
				// The left child was addressed on the revisit, the right one in S_RDL.
				S_RDL: begin
					left_q  <= n_rdata;
					state_q <= S_RDR;
				end
				S_RDR: begin
					right_q <= n_rdata;
					state_q <= S_WRP;
				end
				S_WRP: begin
					sp_q    <= sp_q - SP_W'(1);
					state_q <= (sp_q == SP_W'(1)) ? S_ROOT : S_VISIT;
				end
				S_ROOT: state_q <= S_RWT;
				S_RWT:  state_q <= S_DONE;
				S_DONE: begin
					res_q.longest_run <= n_rdata.best;
					built_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result never reports a run longer than the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.longest_run <= len_q)
		else $error("longest run exceeds length");

	// A failed word carries no run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.longest_run == '0)
		else $error("error result with nonzero run");

	// An accepted build ends with the tree marked built.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> built_q)
		else $error("built mark not set");

	// The walk stack never overflows.
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(DEP))
		else $error("stack overflow");
endmodule
